[hw/rtl/rau_pkg.sv]
// Shared types, codes and defaults of the rational arithmetic unit.
// Used by rau_ctrl, rau_dp and rational_arithmetic_unit; depends on nothing.
package rau_pkg;

  localparam int WIDTH_DEF = 32;
  localparam int IW        = 32;  // field width of the operand words
  localparam int DW        = 64;  // width of exact intermediates
  localparam int DIV_STEPS = DW;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;

  localparam logic [1:0] ORD_LESS    = 2'd0;
  localparam logic [1:0] ORD_EQUAL   = 2'd1;
  localparam logic [1:0] ORD_GREATER = 2'd2;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_ZDEN = 2'd1;
  localparam logic [1:0] ERR_DIV0 = 2'd2;
  localparam logic [1:0] ERR_OVF  = 2'd3;

  typedef enum logic [4:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_X_FROM_A,
    CMD_NEXT_B,
    CMD_B_FROM_X,
    CMD_ZERO_FIX,
    CMD_TWOS,
    CMD_GCD_INIT,
    CMD_GCD_STEP,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_DIV_DONE,
    CMD_MUL1,
    CMD_MUL2,
    CMD_MUL3,
    CMD_FORM,
    CMD_CMP,
    CMD_FINISH,
    CMD_ERR_ZDEN,
    CMD_ERR_DIV0
  } dp_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RED,
    S_GCD,
    S_DIV,
    S_DIVEND,
    S_RED_END,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_FORK,
    S_DONE
  } ctrl_state_t;

  typedef enum logic [1:0] {
    PH_A,
    PH_B,
    PH_R
  } phase_t;

  typedef struct packed {
    dp_cmd_t cmd;
    logic    out_load;
  } rau_cmd_t;

  typedef struct packed {
    logic zden;
    logic x_zero;
    logic both_even;
    logic gcd_done;
    logic div_last;
    logic is_cmp;
    logic is_div;
    logic bmag_zero;
  } rau_status_t;

endpackage

[hw/rtl/rau_ctrl.sv]
// Sequencer of the rational arithmetic unit: handshakes and datapath commands.
// Depends on rau_pkg.
module rau_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  rau_pkg::rau_status_t  status,
  output rau_pkg::rau_cmd_t     cmd
);

  rau_pkg::ctrl_state_t state_r, state_nxt;
  rau_pkg::phase_t      phase_r, phase_nxt;
  logic                 out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rau_pkg::S_IDLE;
      phase_r     <= rau_pkg::PH_A;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    cmd.cmd      = rau_pkg::CMD_IDLE;
    cmd.out_load = 1'b0;
    case (state_r)
      rau_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.cmd   = rau_pkg::CMD_LOAD;
          state_nxt = rau_pkg::S_CHECK;
        end
      end
      rau_pkg::S_CHECK: begin
        if (status.zden) begin
          cmd.cmd   = rau_pkg::CMD_ERR_ZDEN;
          state_nxt = rau_pkg::S_DONE;
        end else begin
          cmd.cmd   = rau_pkg::CMD_X_FROM_A;
          phase_nxt = rau_pkg::PH_A;
          state_nxt = rau_pkg::S_RED;
        end
      end
      rau_pkg::S_RED: begin
        if (status.x_zero) begin
          cmd.cmd   = rau_pkg::CMD_ZERO_FIX;
          state_nxt = rau_pkg::S_RED_END;
        end else if (status.both_even) begin
          cmd.cmd = rau_pkg::CMD_TWOS;
        end else begin
          cmd.cmd   = rau_pkg::CMD_GCD_INIT;
          state_nxt = rau_pkg::S_GCD;
        end
      end
      rau_pkg::S_GCD: begin
        if (status.gcd_done) begin
          cmd.cmd   = rau_pkg::CMD_DIV_INIT;
          state_nxt = rau_pkg::S_DIV;
        end else begin
          cmd.cmd = rau_pkg::CMD_GCD_STEP;
        end
      end
      rau_pkg::S_DIV: begin
        cmd.cmd = rau_pkg::CMD_DIV_STEP;
        if (status.div_last) begin
          state_nxt = rau_pkg::S_DIVEND;
        end
      end
      rau_pkg::S_DIVEND: begin
        cmd.cmd   = rau_pkg::CMD_DIV_DONE;
        state_nxt = rau_pkg::S_RED_END;
      end
      rau_pkg::S_RED_END: begin
        case (phase_r)
          rau_pkg::PH_A: begin
            cmd.cmd   = rau_pkg::CMD_NEXT_B;
            phase_nxt = rau_pkg::PH_B;
            state_nxt = rau_pkg::S_RED;
          end
          rau_pkg::PH_B: begin
            cmd.cmd   = rau_pkg::CMD_B_FROM_X;
            state_nxt = rau_pkg::S_MUL1;
          end
          default: begin
            cmd.cmd   = rau_pkg::CMD_FINISH;
            state_nxt = rau_pkg::S_DONE;
          end
        endcase
      end
      rau_pkg::S_MUL1: begin
        cmd.cmd   = rau_pkg::CMD_MUL1;
        state_nxt = rau_pkg::S_MUL2;
      end
      rau_pkg::S_MUL2: begin
        cmd.cmd   = rau_pkg::CMD_MUL2;
        state_nxt = rau_pkg::S_MUL3;
      end
      rau_pkg::S_MUL3: begin
        cmd.cmd   = rau_pkg::CMD_MUL3;
        state_nxt = rau_pkg::S_FORK;
      end
      rau_pkg::S_FORK: begin
        if (status.is_cmp) begin
          cmd.cmd   = rau_pkg::CMD_CMP;
          state_nxt = rau_pkg::S_DONE;
        end else if (status.is_div && status.bmag_zero) begin
          cmd.cmd   = rau_pkg::CMD_ERR_DIV0;
          state_nxt = rau_pkg::S_DONE;
        end else begin
          cmd.cmd   = rau_pkg::CMD_FORM;
          phase_nxt = rau_pkg::PH_R;
          state_nxt = rau_pkg::S_RED;
        end
      end
      rau_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = rau_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rau_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_load | (out_valid_r & out_stall);
  assign out_valid     = out_valid_r;
  assign in_stall      = (state_r != rau_pkg::S_IDLE);

endmodule

[hw/rtl/rau_dp.sv]
// Datapath of the rational arithmetic unit: operand and work registers,
// binary gcd, twin restoring dividers, 32x32 multiplier. Depends on rau_pkg.
module rau_dp #(
  parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rau_pkg::rau_cmd_t        cmd,
  output rau_pkg::rau_status_t     status,
  input  logic [2:0]               in_operation,
  input  logic signed [31:0]       in_a_num,
  input  logic signed [31:0]       in_a_den,
  input  logic signed [31:0]       in_b_num,
  input  logic signed [31:0]       in_b_den,
  output logic signed [31:0]       out_res_num,
  output logic [30:0]              out_res_den,
  output logic [1:0]               out_order,
  output logic [1:0]               out_error
);

  localparam int DW = rau_pkg::DW;
  localparam int IW = rau_pkg::IW;
  localparam logic [DW-1:0] LIMIT = DW'(1) << (WIDTH - 1);

  function automatic logic [IW-1:0] mag_of(input logic [IW-1:0] v);
    mag_of = v[IW-1] ? (~v + IW'(1)) : v;
  endfunction

  // Raw operands as accepted.
  logic [2:0]    op_r, op_nxt;
  logic [IW-1:0] an_r, an_nxt, ad_r, ad_nxt, bn_r, bn_nxt, bd_r, bd_nxt;
  // Reduced operands.
  logic          a_neg_r, a_neg_nxt, b_neg_r, b_neg_nxt;
  logic [IW-1:0] a_mag_r, a_mag_nxt, a_den_r, a_den_nxt;
  logic [IW-1:0] b_mag_r, b_mag_nxt, b_den_r, b_den_nxt;
  // Working fraction and reduction state.
  logic          x_neg_r, x_neg_nxt;
  logic [DW-1:0] x_mag_r, x_mag_nxt, x_den_r, x_den_nxt;
  logic [DW-1:0] u_r, u_nxt, v_r, v_nxt, g_r, g_nxt;
  logic [DW-1:0] qm_r, qm_nxt, qd_r, qd_nxt, rm_r, rm_nxt, rd_r, rd_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic [DW-1:0] p1_r, p1_nxt, p2_r, p2_nxt, p3_r, p3_nxt;
  // Finished result and the output word.
  logic [31:0]   st_num_r, st_num_nxt;
  logic [30:0]   st_den_r, st_den_nxt;
  logic [1:0]    st_ord_r, st_ord_nxt, st_err_r, st_err_nxt;
  logic [31:0]   o_num_r;
  logic [30:0]   o_den_r;
  logic [1:0]    o_ord_r, o_err_r;

  logic          is_cmp;
  logic [IW-1:0] mul_x, mul_y;
  logic [DW-1:0] mul_p;
  logic [DW:0]   rm_s, rd_s, rm_t, rd_t;
  logic          bn_eff;
  logic signed [DW-1:0] cmp_l, cmp_r;
  logic          ovf;

  always_comb begin
    case (op_r) inside
      [rau_pkg::OP_CMP:3'd7]: is_cmp = 1'b1;
      default:                is_cmp = 1'b0;
    endcase
  end

  always_comb begin
    case (cmd.cmd)
      rau_pkg::CMD_MUL1: begin
        mul_x = a_mag_r;
        mul_y = (op_r == rau_pkg::OP_MUL) ? b_mag_r : b_den_r;
      end
      rau_pkg::CMD_MUL2: begin
        mul_x = b_mag_r;
        mul_y = a_den_r;
      end
      default: begin
        mul_x = a_den_r;
        mul_y = (op_r == rau_pkg::OP_DIV) ? b_mag_r : b_den_r;
      end
    endcase
  end
  assign mul_p = DW'(mul_x) * DW'(mul_y);

  assign rm_s = {rm_r, qm_r[DW-1]};
  assign rd_s = {rd_r, qd_r[DW-1]};
  assign rm_t = rm_s - {1'b0, g_r};
  assign rd_t = rd_s - {1'b0, g_r};

  always_comb begin
    bn_eff = (op_r == rau_pkg::OP_SUB) ? ~b_neg_r : b_neg_r;
    if (b_mag_r == '0) begin
      bn_eff = 1'b0;
    end
  end

  assign cmp_l = a_neg_r ? -$signed(p1_r) : $signed(p1_r);
  assign cmp_r = b_neg_r ? -$signed(p2_r) : $signed(p2_r);
  assign ovf   = (x_neg_r ? (x_mag_r > LIMIT) : (x_mag_r > LIMIT - DW'(1)))
               || (x_den_r > LIMIT - DW'(1));

  always_comb begin
    op_nxt = op_r; an_nxt = an_r; ad_nxt = ad_r; bn_nxt = bn_r; bd_nxt = bd_r;
    a_neg_nxt = a_neg_r; a_mag_nxt = a_mag_r; a_den_nxt = a_den_r;
    b_neg_nxt = b_neg_r; b_mag_nxt = b_mag_r; b_den_nxt = b_den_r;
    x_neg_nxt = x_neg_r; x_mag_nxt = x_mag_r; x_den_nxt = x_den_r;
    u_nxt = u_r; v_nxt = v_r; g_nxt = g_r;
    qm_nxt = qm_r; qd_nxt = qd_r; rm_nxt = rm_r; rd_nxt = rd_r; cnt_nxt = cnt_r;
    p1_nxt = p1_r; p2_nxt = p2_r; p3_nxt = p3_r;
    st_num_nxt = st_num_r; st_den_nxt = st_den_r;
    st_ord_nxt = st_ord_r; st_err_nxt = st_err_r;
    case (cmd.cmd)
      rau_pkg::CMD_LOAD: begin
        op_nxt = in_operation;
        an_nxt = in_a_num; ad_nxt = in_a_den;
        bn_nxt = in_b_num; bd_nxt = in_b_den;
      end
      rau_pkg::CMD_X_FROM_A: begin
        x_neg_nxt = an_r[IW-1] ^ ad_r[IW-1];
        x_mag_nxt = DW'(mag_of(an_r));
        x_den_nxt = DW'(mag_of(ad_r));
      end
      rau_pkg::CMD_NEXT_B: begin
        a_neg_nxt = x_neg_r;
        a_mag_nxt = x_mag_r[IW-1:0];
        a_den_nxt = x_den_r[IW-1:0];
        x_neg_nxt = bn_r[IW-1] ^ bd_r[IW-1];
        x_mag_nxt = DW'(mag_of(bn_r));
        x_den_nxt = DW'(mag_of(bd_r));
      end
      rau_pkg::CMD_B_FROM_X: begin
        b_neg_nxt = x_neg_r;
        b_mag_nxt = x_mag_r[IW-1:0];
        b_den_nxt = x_den_r[IW-1:0];
      end
      rau_pkg::CMD_ZERO_FIX: begin
        x_neg_nxt = 1'b0;
        x_den_nxt = DW'(1);
      end
      rau_pkg::CMD_TWOS: begin
        // Common factors of two come out before the odd gcd is searched.
        x_mag_nxt = x_mag_r >> 1;
        x_den_nxt = x_den_r >> 1;
      end
      rau_pkg::CMD_GCD_INIT: begin
        u_nxt = x_mag_r;
        v_nxt = x_den_r;
      end
      rau_pkg::CMD_GCD_STEP: begin
        if (!u_r[0]) begin
          u_nxt = u_r >> 1;
        end else if (!v_r[0]) begin
          v_nxt = v_r >> 1;
        end else if (u_r >= v_r) begin
          u_nxt = (u_r - v_r) >> 1;
        end else begin
          v_nxt = (v_r - u_r) >> 1;
        end
      end
      rau_pkg::CMD_DIV_INIT: begin
        g_nxt   = u_r | v_r;
        qm_nxt  = x_mag_r;
        qd_nxt  = x_den_r;
        rm_nxt  = '0;
        rd_nxt  = '0;
        cnt_nxt = 7'(rau_pkg::DIV_STEPS);
      end
      rau_pkg::CMD_DIV_STEP: begin
        cnt_nxt = cnt_r - 7'd1;
        if (!rm_t[DW]) begin
          rm_nxt = rm_t[DW-1:0];
          qm_nxt = {qm_r[DW-2:0], 1'b1};
        end else begin
          rm_nxt = rm_s[DW-1:0];
          qm_nxt = {qm_r[DW-2:0], 1'b0};
        end
        if (!rd_t[DW]) begin
          rd_nxt = rd_t[DW-1:0];
          qd_nxt = {qd_r[DW-2:0], 1'b1};
        end else begin
          rd_nxt = rd_s[DW-1:0];
          qd_nxt = {qd_r[DW-2:0], 1'b0};
        end
      end
      rau_pkg::CMD_DIV_DONE: begin
        x_mag_nxt = qm_r;
        x_den_nxt = qd_r;
      end
      rau_pkg::CMD_MUL1: p1_nxt = mul_p;
      rau_pkg::CMD_MUL2: p2_nxt = mul_p;
      rau_pkg::CMD_MUL3: p3_nxt = mul_p;
      rau_pkg::CMD_FORM: begin
        x_den_nxt = p3_r;
        if (op_r == rau_pkg::OP_ADD || op_r == rau_pkg::OP_SUB) begin
          if (a_neg_r == bn_eff) begin
            x_neg_nxt = a_neg_r;
            x_mag_nxt = p1_r + p2_r;
          end else if (p1_r >= p2_r) begin
            x_neg_nxt = a_neg_r;
            x_mag_nxt = p1_r - p2_r;
          end else begin
            x_neg_nxt = bn_eff;
            x_mag_nxt = p2_r - p1_r;
          end
        end else begin
          x_neg_nxt = a_neg_r ^ b_neg_r;
          x_mag_nxt = p1_r;
        end
      end
      rau_pkg::CMD_CMP: begin
        st_num_nxt = '0;
        st_den_nxt = '0;
        st_err_nxt = rau_pkg::ERR_NONE;
        if (cmp_l < cmp_r) begin
          st_ord_nxt = rau_pkg::ORD_LESS;
        end else if (cmp_l > cmp_r) begin
          st_ord_nxt = rau_pkg::ORD_GREATER;
        end else begin
          st_ord_nxt = rau_pkg::ORD_EQUAL;
        end
      end
      rau_pkg::CMD_FINISH: begin
        st_ord_nxt = rau_pkg::ORD_LESS;
        if (ovf) begin
          st_num_nxt = '0;
          st_den_nxt = '0;
          st_err_nxt = rau_pkg::ERR_OVF;
        end else begin
          st_num_nxt = x_neg_r ? (~x_mag_r[31:0] + 32'd1) : x_mag_r[31:0];
          st_den_nxt = x_den_r[30:0];
          st_err_nxt = rau_pkg::ERR_NONE;
        end
      end
      rau_pkg::CMD_ERR_ZDEN: begin
        st_num_nxt = '0; st_den_nxt = '0; st_ord_nxt = rau_pkg::ORD_LESS;
        st_err_nxt = rau_pkg::ERR_ZDEN;
      end
      rau_pkg::CMD_ERR_DIV0: begin
        st_num_nxt = '0; st_den_nxt = '0; st_ord_nxt = rau_pkg::ORD_LESS;
        st_err_nxt = rau_pkg::ERR_DIV0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; an_r <= an_nxt; ad_r <= ad_nxt; bn_r <= bn_nxt; bd_r <= bd_nxt;
    a_neg_r <= a_neg_nxt; a_mag_r <= a_mag_nxt; a_den_r <= a_den_nxt;
    b_neg_r <= b_neg_nxt; b_mag_r <= b_mag_nxt; b_den_r <= b_den_nxt;
    x_neg_r <= x_neg_nxt; x_mag_r <= x_mag_nxt; x_den_r <= x_den_nxt;
    u_r <= u_nxt; v_r <= v_nxt; g_r <= g_nxt;
    qm_r <= qm_nxt; qd_r <= qd_nxt; rm_r <= rm_nxt; rd_r <= rd_nxt;
    p1_r <= p1_nxt; p2_r <= p2_nxt; p3_r <= p3_nxt;
    st_num_r <= st_num_nxt; st_den_r <= st_den_nxt;
    st_ord_r <= st_ord_nxt; st_err_r <= st_err_nxt;
    if (cmd.out_load) begin
      o_num_r <= st_num_r;
      o_den_r <= st_den_r;
      o_ord_r <= st_ord_r;
      o_err_r <= st_err_r;
    end
  end

  assign status.zden      = (ad_r == '0) || (bd_r == '0);
  assign status.x_zero    = (x_mag_r == '0);
  assign status.both_even = !x_mag_r[0] && !x_den_r[0];
  assign status.gcd_done  = (u_r == '0) || (v_r == '0);
  assign status.div_last  = (cnt_r == 7'd1);
  assign status.is_cmp    = is_cmp;
  assign status.is_div    = (op_r == rau_pkg::OP_DIV);
  assign status.bmag_zero = (b_mag_r == '0);

  assign out_res_num = o_num_r;
  assign out_res_den = o_den_r;
  assign out_order   = o_ord_r;
  assign out_error   = o_err_r;

endmodule

[hw/rtl/rational_arithmetic_unit.sv]
// Channel   Handshake            Payload
// in        in_valid / in_stall  in_operation, in_a_num, in_a_den, in_b_num, in_b_den
// out       out_valid/ out_stall out_res_num, out_res_den, out_order, out_error
//
// One word at a time. A word with a zero denominator goes straight to the error
// result. Each nonzero operand fraction passes through the shared binary gcd, one
// shift or subtract per step, and then the 64-step restoring dividers; this runs
// once more for a nonzero result of add, subtract, multiply and divide.
// Reset is synchronous and active low.
// A finished word waits in the output register while the next word is taken;
// only the hand-over to that register waits on out_stall.
// Top level; depends on rau_pkg, rau_ctrl and rau_dp.
module rational_arithmetic_unit #(
  parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_operation,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_res_num,
  output logic [30:0]        out_res_den,
  output logic [1:0]         out_order,
  output logic [1:0]         out_error
);

  rau_pkg::rau_cmd_t    cmd;
  rau_pkg::rau_status_t status;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  rau_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_operation (in_operation),
    .in_a_num     (in_a_num),
    .in_a_den     (in_a_den),
    .in_b_num     (in_b_num),
    .in_b_den     (in_b_den),
    .out_res_num  (out_res_num),
    .out_res_den  (out_res_den),
    .out_order    (out_order),
    .out_error    (out_error)
  );

endmodule

[sim/rational_arithmetic_unit_checker.sv]
// Checker for the rational arithmetic unit: watches both channels, predicts each
// result word from the accepted input word and compares field by field.
// Depends on rau_pkg for the operation, order and error codes.
`timescale 1ns / 1ps
module rational_arithmetic_unit_checker #(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         in_operation,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_res_num,
  input  logic [30:0]        out_res_den,
  input  logic [1:0]         out_order,
  input  logic [1:0]         out_error,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic [1:0]         order;
    logic [1:0]         error;
  } rau_result_t;

  rau_result_t expected_q[$];

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Sign and magnitude of a 32-bit two's complement word.
  function automatic void split_word(logic [31:0] v, output logic neg, output logic [63:0] mag);
    neg = v[31];
    mag = neg ? {32'd0, -v} : {32'd0, v};
  endfunction

  function automatic void lowest_terms(inout logic neg, inout logic [63:0] mag,
                                       inout logic [63:0] den);
    logic [63:0] g;
    if (mag == 0) begin
      neg = 1'b0;
      den = 1;
    end else begin
      g = gcd64(mag, den);
      mag = mag / g;
      den = den / g;
    end
  endfunction

  function automatic rau_result_t predict_result(logic [2:0] op, logic [31:0] an,
      logic [31:0] ad, logic [31:0] bn, logic [31:0] bd);
    rau_result_t r;
    logic an_s, ad_s, bn_s, bd_s, a_neg, b_neg, r_neg, bneg2;
    logic [63:0] a_mag, a_den, b_mag, b_den, r_mag, r_den, m1, m2, lim;
    logic signed [64:0] lv, rv;
    r = '0;
    lim = 64'd1 << (WIDTH - 1);
    if (ad == 0 || bd == 0) begin
      r.error = rau_pkg::ERR_ZDEN;
      return r;
    end
    split_word(an, an_s, a_mag);
    split_word(ad, ad_s, a_den);
    split_word(bn, bn_s, b_mag);
    split_word(bd, bd_s, b_den);
    a_neg = an_s ^ ad_s;
    b_neg = bn_s ^ bd_s;
    lowest_terms(a_neg, a_mag, a_den);
    lowest_terms(b_neg, b_mag, b_den);
    if (op > rau_pkg::OP_DIV) begin
      m1 = a_mag * b_den;
      m2 = b_mag * a_den;
      lv = a_neg ? -$signed({1'b0, m1}) : $signed({1'b0, m1});
      rv = b_neg ? -$signed({1'b0, m2}) : $signed({1'b0, m2});
      r.order = (lv < rv) ? rau_pkg::ORD_LESS :
                ((lv > rv) ? rau_pkg::ORD_GREATER : rau_pkg::ORD_EQUAL);
      return r;
    end
    case (op)
      rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
        bneg2 = (op == rau_pkg::OP_SUB) ? !b_neg : b_neg;
        if (b_mag == 0) bneg2 = 1'b0;
        m1 = a_mag * b_den;
        m2 = b_mag * a_den;
        if (a_neg == bneg2) begin
          r_neg = a_neg;
          r_mag = m1 + m2;
        end else if (m1 >= m2) begin
          r_neg = a_neg;
          r_mag = m1 - m2;
        end else begin
          r_neg = bneg2;
          r_mag = m2 - m1;
        end
        r_den = a_den * b_den;
      end
      rau_pkg::OP_MUL: begin
        r_neg = a_neg ^ b_neg;
        r_mag = a_mag * b_mag;
        r_den = a_den * b_den;
      end
      default: begin
        if (b_mag == 0) begin
          r.error = rau_pkg::ERR_DIV0;
          return r;
        end
        r_neg = a_neg ^ b_neg;
        r_mag = a_mag * b_den;
        r_den = a_den * b_mag;
      end
    endcase
    lowest_terms(r_neg, r_mag, r_den);
    if ((r_neg ? (r_mag > lim) : (r_mag > lim - 1)) || r_den > lim - 1) begin
      r.error = rau_pkg::ERR_OVF;
      return r;
    end
    r.num = r_neg ? -r_mag[31:0] : r_mag[31:0];
    r.den = r_den[30:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  assign pending = expected_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    rau_result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        expected_q.push_back(predict_result(in_operation, in_a_num, in_a_den,
                                            in_b_num, in_b_den));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_res_num !== want.num) report_mismatch("res_num", out_res_num, want.num);
          if (out_res_den !== want.den) report_mismatch("res_den", out_res_den, want.den);
          if (out_order !== want.order) report_mismatch("order", out_order, want.order);
          if (out_error !== want.error) report_mismatch("error", out_error, want.error);
        end
      end
    end
  end
endmodule

[sim/rational_arithmetic_unit_test.sv]
// Testbench top for the rational arithmetic unit: clock, reset, stimulus and verdict.
// Depends on rau_pkg, rational_arithmetic_unit and rational_arithmetic_unit_checker.
`timescale 1ns / 1ps
module rational_arithmetic_unit_test;

  localparam int N_RANDOM = 1080;
  localparam longint CYCLE_LIMIT = 64'd6000000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_operation = '0;
  logic signed [31:0] in_a_num = '0, in_a_den = '0, in_b_num = '0, in_b_den = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_res_num;
  logic [30:0]        out_res_den;
  logic [1:0]         out_order, out_error;
  int                 fail_count, pending;
  longint             cycle_count = 0;
  bit                 sending_done = 0;
  bit                 quiet_phase = 0;
  int                 hold_off = 0;

  rational_arithmetic_unit dut (.*);

  rational_arithmetic_unit_checker chk (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[rational_arithmetic_unit] ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, plus long hold-offs at random while the sender keeps offering.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else if (rst_n && !quiet_phase && $urandom_range(0, 999) == 0 && cycle_count < 200000) begin
      hold_off <= 3000;
      out_stall <= 1'b1;
    end else begin
      out_stall <= quiet_phase ? 1'b0 : ($urandom_range(0, 99) < 6);
    end
  end

  // Values at or near the corners of a signed word, mixed with small and fully random values.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4: return 32'd1;
      5, 6: return $urandom;
      7: return $urandom_range(0, 1) ? $urandom_range(0, 1000) : -$urandom_range(0, 1000);
      default: return $signed($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic logic [31:0] pick_den();
    logic [31:0] v;
    v = pick_value();
    // Zero denominators kept to a trickle so most words reach the arithmetic.
    if (v == 0 && $urandom_range(0, 4) != 0) v = 32'd7;
    return v;
  endfunction

  task automatic send_word(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
    in_valid <= 1'b1;
    in_operation <= op;
    in_a_num <= an;
    in_a_den <= ad;
    in_b_num <= bn;
    in_b_den <= bd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!quiet_phase && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  initial begin
    logic [2:0] op;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_word(rau_pkg::OP_ADD, 1, 2, 1, 3);
    send_word(rau_pkg::OP_SUB, 1, 2, 1, 2);
    send_word(rau_pkg::OP_MUL, -3, 4, 8, -9);
    send_word(rau_pkg::OP_DIV, 3, 4, 0, 5);
    send_word(rau_pkg::OP_DIV, 3, 0, 1, 5);
    send_word(rau_pkg::OP_ADD, 1, 2, 1, 0);
    send_word(rau_pkg::OP_CMP, 1, 3, 2, 6);
    send_word(rau_pkg::OP_CMP, -1, 3, 1, 3);
    send_word(rau_pkg::OP_CMP, 5, 3, 1, 3);
    // Unused operation codes act as compare.
    send_word(3'd5, 1, 2, 1, 3);
    send_word(3'd6, 32'h8000_0000, 1, 32'h7fff_ffff, 1);
    send_word(3'd7, 0, -5, 0, 9);
    send_word(rau_pkg::OP_ADD, 32'h7fff_ffff, 1, 1, 1);
    send_word(rau_pkg::OP_SUB, 32'h8000_0000, 1, 1, 1);
    send_word(rau_pkg::OP_SUB, 32'h8000_0000, 1, 0, 1);
    send_word(rau_pkg::OP_MUL, 32'h8000_0000, 1, -1, 1);
    send_word(rau_pkg::OP_MUL, 1, 32'h8000_0000, 1, 1);
    send_word(rau_pkg::OP_DIV, 1, 32'h7fff_ffff, 1, 32'h7fff_ffff);
    send_word(rau_pkg::OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff);
    send_word(rau_pkg::OP_ADD, 32'h7fff_ffff, 32'h7fff_fffe, 32'h7fff_fffd, 32'h7fff_fffc);
    send_word(rau_pkg::OP_MUL, 0, 32'h8000_0000, 5, 7);
    for (int i = 0; i < N_RANDOM; i++) begin
      quiet_phase = (i >= 400 && i < 550);
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      send_word(op, pick_value(), pick_den(), pick_value(), pick_den());
    end
    in_valid <= 1'b0;
    quiet_phase = 0;
    sending_done = 1;
  end

  initial begin
    wait (sending_done);
    while (pending != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (fail_count == 0) begin
      $display("[rational_arithmetic_unit] OK");
    end else begin
      $display("[rational_arithmetic_unit] ERROR");
    end
    $finish;
  end
endmodule
